// File: hdl/cfb_pkg.sv
package cfb_pkg;

    // byte position within the bytes one item can produce
    typedef logic [3:0] t_pos;

    localparam t_pos POS_HDR_M  = 4'd0;
    localparam t_pos POS_HDR_A  = 4'd1;
    localparam t_pos POS_LEN_LO = 4'd2;
    localparam t_pos POS_LEN_HI = 4'd3;
    localparam t_pos POS_CMD_LO = 4'd4;
    localparam t_pos POS_CMD_HI = 4'd5;
    localparam t_pos POS_DATA   = 4'd6;
    localparam t_pos POS_CHK_LO = 4'd7;
    localparam t_pos POS_CHK_HI = 4'd8;

    localparam logic [7:0]  HDR_M       = 8'h4D;
    localparam logic [7:0]  HDR_A       = 8'h61;
    localparam logic [15:0] TRAILER_LEN = 16'd8;

    // one input item as held by the item register
    typedef struct packed {
        logic [15:0] cmd_code;
        logic [10:0] payload_length;
        logic        has_byte;
        logic [7:0]  data_byte;
        logic        last;
    } t_item;

    // what the item register does this cycle
    typedef struct packed {
        logic fire;
        logic emit;
        t_pos pos;
    } t_step;

    // running byte sum
    function automatic logic [7:0] fold_sum(input logic [7:0] s, input logic [7:0] b);
        logic [8:0] total;
        total = {1'b0, s} + {1'b0, b};
        return total[7:0];
    endfunction

    // rotate left, add sum carry, xor byte
    function automatic logic [7:0] fold_mix(input logic [7:0] s, input logic [7:0] m,
                                            input logic [7:0] b);
        logic [8:0] total;
        logic [7:0] rot;
        total = {1'b0, s} + {1'b0, b};
        rot   = {m[6:0], m[7]};
        return (rot + {7'd0, total[8]}) ^ b;
    endfunction

endpackage

// File: hdl/cfb_item.sv
module cfb_item (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  cfb_pkg::t_item i_item,
    input  logic           i_in_frame,
    input  logic           i_slot_free,
    output logic           o_in_stall,
    output cfb_pkg::t_item o_item,
    output cfb_pkg::t_step o_step
);

    logic           r_hv;
    cfb_pkg::t_pos  r_pos;
    cfb_pkg::t_item r_item;

    cfb_pkg::t_pos  n_pos;
    logic           emit;
    logic           final_byte;
    logic           fire;
    logic           done;
    logic           accept;

    // pick the next position that produces a byte for the held item
    always_comb begin
        emit  = 1'b1;
        n_pos = r_pos;
        if (r_pos < cfb_pkg::POS_DATA && !i_in_frame) begin
            n_pos = r_pos;
        end else if (r_pos <= cfb_pkg::POS_DATA && r_item.has_byte) begin
            n_pos = cfb_pkg::POS_DATA;
        end else if (r_item.last) begin
            n_pos = (r_pos > cfb_pkg::POS_CHK_LO) ? r_pos : cfb_pkg::POS_CHK_LO;
        end else begin
            emit = 1'b0;
        end
    end

    // item finishes when its last byte leaves or it has nothing to give
    assign final_byte = (n_pos == cfb_pkg::POS_CHK_HI)
                      || (n_pos == cfb_pkg::POS_DATA && !r_item.last)
                      || (n_pos == cfb_pkg::POS_CMD_HI && !r_item.has_byte && !r_item.last);
    assign fire       = r_hv && (!emit || i_slot_free);
    assign done       = fire && (!emit || final_byte);
    assign o_in_stall = r_hv && !done;
    assign accept     = i_in_valid && !o_in_stall;

    // item register and byte position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= 1'b0;
            r_pos <= cfb_pkg::POS_HDR_M;
        end else if (accept) begin
            r_hv  <= 1'b1;
            r_pos <= cfb_pkg::POS_HDR_M;
        end else if (done) begin
            r_hv  <= 1'b0;
        end else if (fire) begin
            r_pos <= n_pos + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
    end

    assign o_item      = r_item;
    assign o_step.fire = fire;
    assign o_step.emit = emit;
    assign o_step.pos  = n_pos;

endmodule

// File: hdl/cfb_frame.sv
module cfb_frame (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cfb_pkg::t_item i_item,
    input  cfb_pkg::t_step i_step,
    input  logic           i_out_stall,
    output logic           o_in_frame,
    output logic           o_slot_free,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_frame_end
);

    logic       r_in_frame;
    logic [7:0] r_sum;
    logic [7:0] r_mix;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_end;

    logic [15:0] flen;
    logic [7:0]  n_byte;
    logic [7:0]  base_sum;
    logic [7:0]  base_mix;
    logic        load;

    assign flen = {5'd0, i_item.payload_length} + cfb_pkg::TRAILER_LEN;
    assign load = i_step.fire && i_step.emit;

    // byte for the chosen position
    always_comb begin
        case (i_step.pos)
            cfb_pkg::POS_HDR_M:  n_byte = cfb_pkg::HDR_M;
            cfb_pkg::POS_HDR_A:  n_byte = cfb_pkg::HDR_A;
            cfb_pkg::POS_LEN_LO: n_byte = flen[7:0];
            cfb_pkg::POS_LEN_HI: n_byte = flen[15:8];
            cfb_pkg::POS_CMD_LO: n_byte = i_item.cmd_code[7:0];
            cfb_pkg::POS_CMD_HI: n_byte = i_item.cmd_code[15:8];
            cfb_pkg::POS_DATA:   n_byte = i_item.data_byte;
            cfb_pkg::POS_CHK_LO: n_byte = r_sum;
            cfb_pkg::POS_CHK_HI: n_byte = r_mix;
            default:             n_byte = 8'd0;
        endcase
    end

    // checksum restarts on the frame's first header byte
    assign base_sum = (i_step.pos == cfb_pkg::POS_HDR_M) ? 8'd0 : r_sum;
    assign base_mix = (i_step.pos == cfb_pkg::POS_HDR_M) ? 8'd0 : r_mix;

    // frame state and check bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_sum      <= 8'd0;
            r_mix      <= 8'd0;
        end else if (load) begin
            if (i_step.pos <= cfb_pkg::POS_DATA) begin
                r_sum <= cfb_pkg::fold_sum(base_sum, n_byte);
                r_mix <= cfb_pkg::fold_mix(base_sum, base_mix, n_byte);
            end
            if (i_step.pos == cfb_pkg::POS_CMD_HI) begin
                r_in_frame <= 1'b1;
            end
            if (i_step.pos == cfb_pkg::POS_CHK_HI) begin
                r_in_frame <= 1'b0;
                r_sum      <= 8'd0;
                r_mix      <= 8'd0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_end  <= (i_step.pos == cfb_pkg::POS_CHK_HI);
        end
    end

    assign o_in_frame  = r_in_frame;
    assign o_slot_free = !r_ov || !i_out_stall;
    assign o_out_valid = r_ov;
    assign o_out_byte  = r_byte;
    assign o_frame_end = r_end;

endmodule

// File: hdl/checksummed_frame_builder_top.sv
// Frame builder: each item carries at most one payload byte and the block sends
// the framed packet out one byte per cycle while the output is not stalled. A
// frame's first item gives the six header bytes ('M', 'a', length and command
// code, both low byte first), an item with a byte gives that byte, and the last
// item adds the two check bytes, the second flagged by o_frame_end. An item is
// held until it has handed all its bytes to the single output byte register, up
// to 9, and leaves at once when it produces none. The next item is taken in the
// cycle its predecessor hands over its final byte, so a run of payload bytes
// streams at one item per cycle while the output is not stalled.
module checksummed_frame_builder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_cmd_code,
    input  logic [10:0] i_payload_length,
    input  logic        i_has_byte,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end
);

    cfb_pkg::t_item in_item;
    cfb_pkg::t_item held_item;
    cfb_pkg::t_step step;
    logic           in_frame;
    logic           slot_free;

    assign in_item.cmd_code       = i_cmd_code;
    assign in_item.payload_length = i_payload_length;
    assign in_item.has_byte       = i_has_byte;
    assign in_item.data_byte      = i_data_byte;
    assign in_item.last           = i_last;

    // item register and byte sequencing
    cfb_item u_item (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_item      (in_item),
        .i_in_frame  (in_frame),
        .i_slot_free (slot_free),
        .o_in_stall  (o_in_stall),
        .o_item      (held_item),
        .o_step      (step)
    );

    // frame state, checksum and output register
    cfb_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (held_item),
        .i_step      (step),
        .i_out_stall (i_out_stall),
        .o_in_frame  (in_frame),
        .o_slot_free (slot_free),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end)
    );

endmodule

// File: hdl/cfb_checker.sv
module cfb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_frame_end
);

    logic r_expect_m;
    logic r_expect_a;
    logic out_take;

    assign out_take = o_out_valid && !i_out_stall;

    // track frame start from the output side
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_m <= 1'b1;
            r_expect_a <= 1'b0;
        end else if (out_take) begin
            r_expect_m <= o_frame_end;
            r_expect_a <= r_expect_m;
        end
    end

    // a stalled item keeps its byte
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_frame_end))
        else $error("output item changed while stalled");

    // every frame opens with 'M'
    a_start_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && r_expect_m |-> o_out_byte == cfb_pkg::HDR_M)
        else $error("frame does not start with M");

    // and 'a' follows
    a_start_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_take && r_expect_a |-> o_out_byte == cfb_pkg::HDR_A && !o_frame_end)
        else $error("second frame byte is not a");

    // a held item with a free output slot produces a byte next cycle
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall && !o_out_valid |=> o_out_valid)
        else $error("input stalled with empty output");

endmodule

bind checksummed_frame_builder_top cfb_checker u_cfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_byte  (o_out_byte),
    .o_frame_end (o_frame_end)
);
